>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> hw/rtl/bis_pkg.sv
// shared types and codes of the bounded integer stack
package bis_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // movement of the cell chain at a clock edge
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP,
        OP_ROTATE
    } shift_op_t;

endpackage

>>> hw/rtl/bis_cell.sv
// one storage cell of the stack chain; cell 0 is the top of stack
module bis_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int COUNT_W    = 7,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  bis_pkg::shift_op_t    op,
    input  logic [COUNT_W-1:0]    count,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic [DATA_WIDTH-1:0] next_data,
    input  logic [DATA_WIDTH-1:0] head_data,
    output logic [DATA_WIDTH-1:0] data
);
    import bis_pkg::*;

    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(IDX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            OP_PUSH:   data_next = prev_data;
            OP_POP:    data_next = next_data;
            // the deepest held cell wraps around to take the top entry
            OP_ROTATE: data_next = (count == LAST_COUNT) ? head_data : next_data;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> hw/rtl/bounded_integer_stack.sv
// top level of the bounded integer stack: command control around a chain of cells
//
// Commands enter on start/cmd/operand and transfer at a clock edge where start is
// high and busy is low. Each command gives exactly one result on status, value,
// found_index, entry_count, is_full and is_empty, shown for one cycle with done.
// The receiver cannot stall; results must be taken in the cycle they appear.
//
// Push, pop, peek, clear and unused codes: result in the cycle after the transfer,
// and a new command may transfer every cycle.
// Search: the held entries rotate through the cell chain one cell per cycle and
// the top cell is compared with the key; the result appears once every held entry
// has been compared (right after the transfer on an empty stack); busy is high meanwhile.
// The rotation runs a full turn, leaving the stack order unchanged.
//
// The capacity register is written through cfg_we/cfg_wdata, by the user only while
// idle; the block itself does not enforce this. Values above DEPTH act as DEPTH.
// Reset empties the stack and sets capacity to 64; cell contents are not cleared.
module bounded_integer_stack #(
    parameter  int DEPTH      = 64,
    parameter  int DATA_WIDTH = 32,
    localparam int COUNT_W    = $clog2(DEPTH + 1),
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bis_pkg::CMD_W-1:0]    cmd,
    input  logic signed [DATA_WIDTH-1:0] operand,
    input  logic                         cfg_we,
    input  logic [bis_pkg::CAP_W-1:0]    cfg_wdata,
    output logic                         done,
    output logic [bis_pkg::STATUS_W-1:0] status,
    output logic signed [DATA_WIDTH-1:0] value,
    output logic [IDX_W-1:0]             found_index,
    output logic [COUNT_W-1:0]           entry_count,
    output logic                         is_full,
    output logic                         is_empty
);
    import bis_pkg::*;

    localparam int CMP_W = (CAP_W > COUNT_W) ? CAP_W : COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [CAP_W-1:0]      capacity_reg, capacity_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [COUNT_W-1:0]    step_reg, step_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [IDX_W-1:0]      found_reg, found_next;
    logic [COUNT_W-1:0]    entry_count_reg;
    logic                  full_reg, full_next;
    logic                  empty_reg, empty_next;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    shift_op_t             cell_op;
    logic [COUNT_W-1:0]    cap_eff;
    logic                  can_push;
    logic                  accept;
    logic [DATA_WIDTH-1:0] head;
    logic                  match;
    logic [IDX_W-1:0]      cur_idx;
    logic                  last_step;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_d;
        logic [DATA_WIDTH-1:0] next_d;

        if (g == 0)
        begin : g_top
            assign prev_d = operand;
        end
        else
        begin : g_mid
            assign prev_d = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_bottom
            assign next_d = cell_data[g];
        end
        else
        begin : g_upper
            assign next_d = cell_data[g+1];
        end

        bis_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .COUNT_W    (COUNT_W),
            .IDX        (g)
        ) u_cell (
            .clk       (clk),
            .op        (cell_op),
            .count     (count_reg),
            .prev_data (prev_d),
            .next_data (next_d),
            .head_data (cell_data[0]),
            .data      (cell_data[g])
        );
    end

    assign head   = cell_data[0];
    assign match  = (head == key_reg);
    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        if (CMP_W'(capacity_reg) > CMP_W'(DEPTH))
            cap_eff = COUNT_W'(DEPTH);
        else
            cap_eff = COUNT_W'(capacity_reg);
    end

    assign can_push  = (count_reg < cap_eff);
    // step k compares the entry k places below the top
    assign cur_idx   = IDX_W'(count_reg - step_reg - COUNT_W'(1));
    assign last_step = (step_reg == count_reg - COUNT_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        capacity_next = capacity_reg;
        key_next      = key_reg;
        step_next     = step_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        value_next    = value_reg;
        found_next    = found_reg;
        cell_op       = OP_HOLD;

        if (cfg_we)
            capacity_next = cfg_wdata;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    value_next  = '0;
                    found_next  = '0;
                    case (cmd)
                        CMD_PUSH:
                        begin
                            if (can_push)
                            begin
                                cell_op    = OP_PUSH;
                                count_next = count_reg + COUNT_W'(1);
                            end
                            else
                                status_next = STATUS_FULL;
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            if (count_reg == '0)
                                status_next = STATUS_EMPTY;
                            else
                            begin
                                value_next = head;
                                if (cmd == CMD_POP)
                                begin
                                    cell_op    = OP_POP;
                                    count_next = count_reg - COUNT_W'(1);
                                end
                            end
                        end
                        CMD_CLEAR:
                            count_next = '0;
                        CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                                status_next = STATUS_NOT_FOUND;
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_SEARCH;
                                key_next   = operand;
                                step_next  = '0;
                                hit_next   = 1'b0;
                            end
                        end
                        default:
                            status_next = STATUS_OK;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cell_op   = OP_ROTATE;
                step_next = step_reg + COUNT_W'(1);
                if (!hit_reg && match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cur_idx;
                end
                if (last_step)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    value_next = '0;
                    if (hit_reg)
                    begin
                        status_next = STATUS_OK;
                        found_next  = hit_idx_reg;
                    end
                    else if (match)
                    begin
                        status_next = STATUS_OK;
                        found_next  = cur_idx;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                        found_next  = '0;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        full_next  = (count_next >= cap_eff);
        empty_next = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            capacity_reg    <= CAP_RESET;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            step_reg        <= '0;
            entry_count_reg <= '0;
            full_reg        <= 1'b0;
            empty_reg       <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            capacity_reg    <= capacity_next;
            done_reg        <= done_next;
            hit_reg         <= hit_next;
            step_reg        <= step_next;
            entry_count_reg <= count_next;
            full_reg        <= full_next;
            empty_reg       <= empty_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        hit_idx_reg <= hit_idx_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
        found_reg   <= found_next;
    end

    assign busy        = (state_reg == S_SEARCH);
    assign done        = done_reg;
    assign status      = status_reg;
    assign value       = value_reg;
    assign found_index = found_reg;
    assign entry_count = entry_count_reg;
    assign is_full     = full_reg;
    assign is_empty    = empty_reg;

endmodule

>>> hw/rtl/bis_checker.sv
// port-level checker for the bounded integer stack, bound to the top level
`include "assert_macros.svh"

module bis_checker #(
    parameter  int DEPTH      = 64,
    parameter  int DATA_WIDTH = 32,
    localparam int COUNT_W    = $clog2(DEPTH + 1),
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [bis_pkg::STATUS_W-1:0] status,
    input logic signed [DATA_WIDTH-1:0] value,
    input logic [IDX_W-1:0]             found_index,
    input logic [COUNT_W-1:0]           entry_count,
    input logic                         is_full,
    input logic                         is_empty
);
    import bis_pkg::*;

    logic empty_result_ok;

    // failed pop or peek gives zero data on an empty stack
    assign empty_result_ok = is_empty && (value == '0) && (found_index == '0);

    // a transfer leads either to a result or to a running search
    `ASSERT_NEXT(a_xfer_progress, clk, rst_n, start && !busy, busy || done)
    // a result never appears while a search is still running
    `ASSERT_IMPLIES(a_done_not_busy, clk, rst_n, done, !busy)
    `ASSERT_IMPLIES(a_empty_flag, clk, rst_n, done, is_empty == (entry_count == '0))
    `ASSERT_IMPLIES(a_full_status, clk, rst_n, done && (status == STATUS_FULL), is_full)
    `ASSERT_IMPLIES(a_empty_status, clk, rst_n, done && (status == STATUS_EMPTY), empty_result_ok)

endmodule

bind bounded_integer_stack bis_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_bis_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .value       (value),
    .found_index (found_index),
    .entry_count (entry_count),
    .is_full     (is_full),
    .is_empty    (is_empty)
);

>>> tb/sv/tb.sv
// testbench for the bounded integer stack: directed and random commands against a predictor
`timescale 1ns / 100ps

module tb;
    import bis_pkg::*;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 7;

    // codes the block treats as no operation
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    localparam logic [CAP_W-1:0] CAP_ZERO = 7'd0;
    localparam logic [CAP_W-1:0] CAP_MAX  = 7'd127;

    typedef enum {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_mode_t;

    typedef struct {
        logic [STATUS_W-1:0]         status;
        logic signed [DATA_WIDTH-1:0] value;
        logic [IDX_W-1:0]            found_index;
        logic [COUNT_W-1:0]          entry_count;
        logic                        is_full;
        logic                        is_empty;
    } stack_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [CMD_W-1:0]             cmd;
    logic signed [DATA_WIDTH-1:0] operand;
    logic                         cfg_we;
    logic [CAP_W-1:0]             cfg_wdata;
    logic                         done;
    logic [STATUS_W-1:0]          status;
    logic signed [DATA_WIDTH-1:0] value;
    logic [IDX_W-1:0]             found_index;
    logic [COUNT_W-1:0]           entry_count;
    logic                         is_full;
    logic                         is_empty;

    // predictor state
    logic signed [DATA_WIDTH-1:0] stack_cells [DEPTH];
    int                           held_count;
    int                           capacity_setting;

    stack_result_t expected_results [$];
    int            error_count;
    int            issue_gap_pct;

    bounded_integer_stack #(
        .DEPTH     (DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .operand    (operand),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .status     (status),
        .value      (value),
        .found_index(found_index),
        .entry_count(entry_count),
        .is_full    (is_full),
        .is_empty   (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    function automatic stack_result_t predict_stack_result(logic [CMD_W-1:0] op,
                                                           logic signed [DATA_WIDTH-1:0] key);
        stack_result_t r;
        int            usable;
        r.status      = STATUS_OK;
        r.value       = '0;
        r.found_index = '0;
        usable = (capacity_setting > DEPTH) ? DEPTH : capacity_setting;
        case (op)
            CMD_PUSH:
                if (held_count >= usable)
                    r.status = STATUS_FULL;
                else
                begin
                    stack_cells[held_count] = key;
                    held_count++;
                end
            CMD_POP, CMD_PEEK:
                if (held_count == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    r.value = stack_cells[held_count - 1];
                    if (op == CMD_POP)
                        held_count--;
                end
            CMD_CLEAR:
                held_count = 0;
            CMD_SEARCH:
            begin
                r.status = STATUS_NOT_FOUND;
                // scanning upward leaves the topmost match
                for (int i = 0; i < held_count; i++)
                    if (stack_cells[i] == key)
                    begin
                        r.status      = STATUS_OK;
                        r.found_index = i[IDX_W-1:0];
                    end
            end
            default: ;
        endcase
        r.entry_count = held_count[COUNT_W-1:0];
        r.is_full     = (held_count >= usable);
        r.is_empty    = (held_count == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [DATA_WIDTH-1:0] want,
                                        logic [DATA_WIDTH-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    // every result is taken in the cycle done is shown
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no command outstanding");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, status);
                check_field("value", want.value, value);
                check_field("found_index", want.found_index, found_index);
                check_field("entry_count", want.entry_count, entry_count);
                check_field("is_full", want.is_full, is_full);
                check_field("is_empty", want.is_empty, is_empty);
            end
        end
    end

    // returns at the rising edge of the transfer
    task automatic issue_command(logic [CMD_W-1:0] op, logic signed [DATA_WIDTH-1:0] key);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < issue_gap_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        cmd     <= op;
        operand <= key;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(predict_stack_result(op, key));
    endtask

    task automatic drain_commands();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        capacity_setting = cap;
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] pick_operand(bit for_search);
        int r;
        if (for_search && held_count > 0 && $urandom_range(99) < 60)
            return stack_cells[$urandom_range(held_count - 1)];
        r = $urandom_range(9);
        case (r)
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3, 4: return $urandom_range(7);   // small values give duplicates
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(traffic_mode_t mode);
        int r;
        int push_lim, pop_lim, peek_lim, search_lim, rsvd_lim;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL:  begin push_lim = 75; pop_lim = 83; peek_lim = 88; search_lim = 98;
                              rsvd_lim = 99; end
            MODE_DRAIN: begin push_lim = 15; pop_lim = 65; peek_lim = 75; search_lim = 95;
                              rsvd_lim = 98; end
            default:    begin push_lim = 35; pop_lim = 60; peek_lim = 72; search_lim = 92;
                              rsvd_lim = 97; end
        endcase
        if (r < push_lim)   return CMD_PUSH;
        if (r < pop_lim)    return CMD_POP;
        if (r < peek_lim)   return CMD_PEEK;
        if (r < search_lim) return CMD_SEARCH;
        if (r < rsvd_lim)   return logic'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)) ?
                                   CMD_RSVD_LO : CMD_RSVD_LO;
        return CMD_CLEAR;
    endfunction

    task automatic test_directed_edges();
        drain_commands();
        write_capacity(CAP_RESET);
        issue_command(CMD_POP, 32'sd0);
        issue_command(CMD_PEEK, 32'sd0);
        issue_command(CMD_SEARCH, 32'sd0);            // search on empty stack
        issue_command(CMD_PUSH, 32'sh8000_0000);
        issue_command(CMD_PUSH, 32'sh7fff_ffff);
        issue_command(CMD_PUSH, -32'sd1);
        issue_command(CMD_PUSH, 32'sd0);
        issue_command(CMD_PEEK, 32'sd0);
        issue_command(CMD_SEARCH, -32'sd1);
        issue_command(CMD_SEARCH, 32'sh8000_0000);
        issue_command(CMD_PUSH, 32'sh7fff_ffff);
        issue_command(CMD_SEARCH, 32'sh7fff_ffff);    // topmost of two matches
        issue_command(CMD_SEARCH, 32'sd12345);
        issue_command(CMD_RSVD_LO, $urandom);
        issue_command(CMD_RSVD_MID, $urandom);
        issue_command(CMD_RSVD_HI, $urandom);
        issue_command(CMD_POP, 32'sd0);
        issue_command(CMD_CLEAR, 32'sd0);
        issue_command(CMD_PUSH, 32'sh5a5a_5a5a);      // cell reused after clear
        issue_command(CMD_POP, 32'sd0);
        drain_commands();
    endtask

    task automatic test_capacity_limits();
        write_capacity(CAP_ZERO);
        issue_command(CMD_PUSH, 32'sd1);              // zero capacity: full and empty
        drain_commands();
        write_capacity(7'd3);
        repeat (4) issue_command(CMD_PUSH, $urandom);
        drain_commands();
        write_capacity(7'd1);                          // capacity now below entry count
        issue_command(CMD_PUSH, 32'sd9);
        issue_command(CMD_POP, 32'sd0);
        issue_command(CMD_POP, 32'sd0);
        issue_command(CMD_PUSH, 32'sd9);
        issue_command(CMD_POP, 32'sd0);
        drain_commands();
        write_capacity(CAP_MAX);                       // saturates at the built depth
        issue_command(CMD_PUSH, 32'sd2);
        issue_command(CMD_CLEAR, 32'sd0);
        drain_commands();
    endtask

    task automatic run_segment(logic [CAP_W-1:0] cap, int n_items);
        traffic_mode_t    mode;
        int               run_left;
        logic [CMD_W-1:0] op;
        drain_commands();
        write_capacity(cap);
        mode     = MODE_FILL;
        run_left = $urandom_range(40, 90);
        for (int k = 0; k < n_items; k++)
        begin
            if (run_left == 0)
            begin
                mode     = traffic_mode_t'($urandom_range(2));
                run_left = $urandom_range(15, 50);
            end
            run_left--;
            // now and then hold off until every result is back
            if ($urandom_range(99) == 0)
                drain_commands();
            op = pick_command(mode);
            if (op == CMD_RSVD_LO)
                op = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            issue_command(op, pick_operand(op == CMD_SEARCH));
        end
    endtask

    task automatic test_random_traffic(int gap_pct);
        issue_gap_pct = gap_pct;
        run_segment(CAP_RESET, 140);
        run_segment(CAP_MAX, 140);
        run_segment(CAP_W'($urandom_range(1, 16)), 60);
        run_segment(CAP_W'($urandom_range(17, 63)), 80);
        run_segment(CAP_ZERO, 20);
        drain_commands();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = CMD_PUSH;
        operand   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        error_count   = 0;
        issue_gap_pct = 0;
        held_count    = 0;
        capacity_setting = CAP_RESET;
        foreach (stack_cells[i])
            stack_cells[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_capacity_limits();
        test_random_traffic(31);
        test_random_traffic(70);
        test_random_traffic(0);

        drain_commands();
        repeat (70) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bis_pkg.sv
hw/rtl/bis_cell.sv
hw/rtl/bounded_integer_stack.sv
hw/rtl/bis_checker.sv
tb/sv/tb.sv
